// ===== hw/rtl/ntmk_pkg.sv =====
package ntmk_pkg;

  // chord storage
  localparam int MAX_CHORD_NOTES = 8;
  localparam int CNT_W  = $clog2(MAX_CHORD_NOTES + 2);  // count saturates at MAX+1
  localparam int NUM_W  = $clog2(MAX_CHORD_NOTES + 1);  // keys handed to the back end
  localparam int KIDX_W = (MAX_CHORD_NOTES > 1) ? $clog2(MAX_CHORD_NOTES) : 1;

  localparam int KEY_W = 7;
  localparam int DUR_W = 11;
  localparam int DEN_W = 12;
  localparam int OCT_W = 4;

  localparam logic [DEN_W-1:0] DEN_SAT = {DEN_W{1'b1}};
  localparam logic [OCT_W-1:0] DEFAULT_OCTAVE_RST = 4'd4;
  localparam logic [KEY_W:0]   KEY_MAX = 8'd127;

  // durations, 480 ticks per quarter
  localparam int TICKS_PER_QUARTER = 480;
  localparam int WHOLE_TICKS       = 4 * TICKS_PER_QUARTER;
  localparam int DIV_W             = 13;  // holds 2*whole + den and 2*den
  localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(2 * WHOLE_TICKS);
  localparam logic [DUR_W-1:0] DUR_PLAIN = DUR_W'(TICKS_PER_QUARTER);

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ST_NOTE = 2'd0,
    ST_REST = 2'd1,
    ST_BAD  = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  // one closed token, front to back
  typedef struct packed {
    status_t                                status;
    logic [NUM_W-1:0]                       num;
    logic [MAX_CHORD_NOTES-1:0][KEY_W-1:0]  keys;
    logic                                   has_den;
    logic [DEN_W-1:0]                       den;
  } tok_sum_t;

  // letters A..G
  function automatic logic [3:0] semitone_of(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0: s = 4'd9;
      3'd1: s = 4'd11;
      3'd2: s = 4'd0;
      3'd3: s = 4'd2;
      3'd4: s = 4'd4;
      3'd5: s = 4'd5;
      3'd6: s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/note_token_to_midi_keys.sv =====
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata[7:0] text_byte, tlast end_of_token
// out_    | out | out_tvalid/tready  | tdata[6:0] midi_key, [17:7] duration_ticks,
//         |     |                    | tuser[1:0] status, tlast last_in_run
// cfg_    | in  | cfg_valid/ready    | cfg_data[3:0] default_octave
//
// Input: one character item per cycle while in_tready is high; the token closes
// with its last one. Back end per token: pop, then the bit-serial duration divide
// when a denominator is present, then the result items in order.
// Reset (rst_n low, synchronous) clears parser, queue and output; default_octave
// returns to 4. in_tready drops only while the two-entry token queue is full;
// a stalled output holds its item and holds the back end in its emit state.
module note_token_to_midi_keys (
  input  logic        clk,
  input  logic        rst_n,
  // character items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_token
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [6:0] midi_key, [17:7] duration_ticks, [23:18] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // last_in_run
  // default octave register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // [3:0] default_octave
);
  import ntmk_pkg::*;

  tok_sum_t push_data;
  tok_sum_t pop_data;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  // front: character parser, chord key store, token summary
  ntmk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // closed tokens waiting for the back end
  ntmk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // back: duration divide and result sequencing
  ntmk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/ntmk_front.sv =====
module ntmk_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [7:0] text_byte
  input  logic                    in_tlast,   // end_of_token
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [3:0]              cfg_data,   // default_octave
  output logic                    push,
  output ntmk_pkg::tok_sum_t      push_data,
  input  logic                    full
);
  import ntmk_pkg::*;

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_REST  = "r";
  localparam logic [7:0] CH_SHARP = "#";
  localparam logic [7:0] CH_FLAT  = "b";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_G     = "G";

  typedef enum logic [4:0] {
    PH_FIRST  = 5'b00001,
    PH_SHARPS = 5'b00010,
    PH_FLATS  = 5'b00100,
    PH_OCTAVE = 5'b01000,
    PH_REST   = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [2:0]       len;
    logic [3:0]       semi;
    logic [1:0]       sharps;
    logic [1:0]       flats;
    logic [OCT_W-1:0] oct;
    logic             rest_part;
    logic             saw_rest;
    logic             bad;
    logic             ovf;
    logic             in_den;
    logic [DEN_W-1:0] den_val;
    logic             den_dig;
    logic             den_neg;
    logic [CNT_W-1:0] count;
  } tok_t;

  typedef struct packed {
    tok_t              t;
    logic              wr;
    logic [KIDX_W-1:0] idx;
    logic [KEY_W-1:0]  key;
  } close_t;

  function automatic tok_t clear_part(input tok_t t);
    tok_t r;
    r = t;
    r.phase     = PH_FIRST;
    r.len       = '0;
    r.semi      = '0;
    r.sharps    = '0;
    r.flats     = '0;
    r.oct       = '0;
    r.rest_part = 1'b0;
    return r;
  endfunction

  function automatic tok_t clear_token();
    tok_t r;
    r = '0;
    r = clear_part(r);
    return r;
  endfunction

  function automatic close_t close_part(input tok_t t, input logic [OCT_W-1:0] dflt);
    close_t           r;
    logic [OCT_W-1:0] o;
    logic [8:0]       key;
    r.t   = t;
    r.wr  = 1'b0;
    r.idx = t.count[KIDX_W-1:0];
    r.key = '0;
    o   = (t.phase == PH_OCTAVE) ? t.oct : dflt;
    // 12*(o+1) + semitone + sharps - flats; never below 9
    key = 9'({o, 3'b000}) + 9'({o, 2'b00}) + 9'd12 + 9'(t.semi)
        + 9'(t.sharps) - 9'(t.flats);
    if (t.phase == PH_FIRST) begin
      r.t.bad = 1'b1;
    end else if (t.rest_part) begin
      r.t = clear_part(t);
      r.t.saw_rest = 1'b1;
    end else if (key > 9'(KEY_MAX)) begin
      r.t.bad = 1'b1;
    end else begin
      if (t.count < CNT_W'(MAX_CHORD_NOTES)) begin
        r.wr  = 1'b1;
        r.key = key[KEY_W-1:0];
      end else begin
        r.t.ovf = 1'b1;
      end
      r.t = clear_part(r.t);
      if (t.count <= CNT_W'(MAX_CHORD_NOTES)) begin
        r.t.count = t.count + CNT_W'(1);
      end
    end
    return r;
  endfunction

  tok_t                                  tok_r, tok_nxt;
  logic [OCT_W-1:0]                      dflt_r, dflt_nxt;
  logic [MAX_CHORD_NOTES-1:0][KEY_W-1:0] keys_r, keys_nxt;

  tok_t              t;
  close_t            cr;
  logic              accept;
  logic              wr;
  logic [KIDX_W-1:0] widx;
  logic [KEY_W-1:0]  wkey;
  logic [15:0]       prod;
  logic              den_bad;
  logic [7:0]        c;

  assign in_tready = !full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;

  always_comb begin
    t    = tok_r;
    cr   = '0;
    wr   = 1'b0;
    widx = '0;
    wkey = '0;
    prod = '0;
    den_bad = 1'b0;

    if (!t.bad) begin
      if (t.in_den) begin
        if ((c == CH_PLUS || c == CH_MINUS) && t.len == 3'd0) begin
          t.den_neg = (c == CH_MINUS);
        end else if (c >= CH_0 && c <= CH_9) begin
          prod = 16'({t.den_val, 3'b000}) + 16'({t.den_val, 1'b0}) + 16'(c[3:0]);
          t.den_val = (prod > 16'(DEN_SAT)) ? DEN_SAT : prod[DEN_W-1:0];
          t.den_dig = 1'b1;
        end else begin
          t.bad = 1'b1;
        end
        t.len = 3'd1;
      end else if (c == CH_PLUS || c == CH_SLASH) begin
        cr = close_part(t, dflt_r);
        t  = cr.t;
        if (cr.wr) begin
          wr = 1'b1; widx = cr.idx; wkey = cr.key;
        end
        if (c == CH_SLASH) begin
          t.in_den = 1'b1;
          t.len    = 3'd0;
        end
      end else if (t.len >= 3'd4) begin
        t.bad = 1'b1;
      end else begin
        t.len = t.len + 3'd1;
        case (t.phase)
          PH_FIRST: begin
            if (c == CH_REST || c == CH_MINUS) begin
              t.rest_part = 1'b1;
              t.phase     = PH_REST;
            end else if (c >= CH_A && c <= CH_G) begin
              t.semi  = semitone_of(3'(c - CH_A));
              t.phase = PH_SHARPS;
            end else begin
              t.bad = 1'b1;
            end
          end
          PH_SHARPS, PH_FLATS: begin
            if (c == CH_SHARP && t.phase == PH_SHARPS) begin
              t.sharps = t.sharps + 2'd1;
            end else if (c == CH_FLAT) begin
              t.flats = t.flats + 2'd1;
              t.phase = PH_FLATS;
            end else if (c >= CH_0 && c <= CH_9) begin
              t.oct   = c[3:0];
              t.phase = PH_OCTAVE;
            end else begin
              t.bad = 1'b1;
            end
          end
          default: t.bad = 1'b1;
        endcase
      end
    end

    // token close; a '+' just before it leaves an empty part, so at most one key write
    if (in_tlast && !t.bad && !t.in_den) begin
      cr = close_part(t, dflt_r);
      t  = cr.t;
      if (cr.wr) begin
        wr = 1'b1; widx = cr.idx; wkey = cr.key;
      end
    end

    keys_nxt = keys_r;
    if (wr) keys_nxt[widx] = wkey;

    den_bad = !t.bad && t.in_den && (!t.den_dig || t.den_neg || t.den_val == '0);

    push_data.keys    = keys_nxt;
    push_data.num     = NUM_W'(t.count);
    push_data.has_den = t.in_den;
    push_data.den     = t.den_val;
    if (t.bad || den_bad)        push_data.status = ST_BAD;
    else if (t.ovf)              push_data.status = ST_OVF;
    else if (t.count != '0)      push_data.status = ST_NOTE;
    else                         push_data.status = ST_REST;

    tok_nxt = tok_r;
    if (accept) tok_nxt = in_tlast ? clear_token() : t;

    dflt_nxt = (cfg_valid && cfg_ready) ? cfg_data : dflt_r;
  end

  assign push = accept && in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= clear_token();
      dflt_r <= DEFAULT_OCTAVE_RST;
    end else begin
      tok_r  <= tok_nxt;
      dflt_r <= dflt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) keys_r <= keys_nxt;
  end

endmodule

// ===== hw/rtl/ntmk_fifo.sv =====
module ntmk_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ntmk_pkg::tok_sum_t  push_data,
  output logic                full,
  input  logic                pop,
  output ntmk_pkg::tok_sum_t  pop_data,
  output logic                empty
);
  import ntmk_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FCNT_W = $clog2(QDEPTH + 1);

  tok_sum_t            mem [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == FCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + FCNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - FCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/ntmk_back.sv =====
module ntmk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  ntmk_pkg::tok_sum_t  pop_data,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [6:0] midi_key, [17:7] duration_ticks, rest 0
  output logic [1:0]          out_tuser,  // [1:0] status
  output logic                out_tlast   // last_in_run
);
  import ntmk_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_EMIT = 3'b100
  } bk_state_t;

  localparam int STEP_W = $clog2(DIV_W + 1);

  bk_state_t          st_r, st_nxt;
  tok_sum_t           ent_r, ent_nxt;
  logic [DIV_W-1:0]   num_r, num_nxt;
  logic [DIV_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic [KIDX_W-1:0]  idx_r, idx_nxt;
  logic               ov_r, ov_nxt;
  logic [1:0]         ou_r, ou_nxt;
  logic [KEY_W-1:0]   ok_r, ok_nxt;
  logic [DUR_W-1:0]   od_r, od_nxt;
  logic               ol_r, ol_nxt;

  logic [DIV_W:0]     rem_sh;
  logic               qbit;
  logic [DIV_W-1:0]   qfin;
  logic               load;
  logic               lastk;

  always_comb begin
    st_nxt   = st_r;
    ent_nxt  = ent_r;
    num_nxt  = num_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    dur_nxt  = dur_r;
    idx_nxt  = idx_r;
    ou_nxt   = ou_r;
    ok_nxt   = ok_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    pop      = 1'b0;
    load     = 1'b0;
    lastk    = 1'b0;

    rem_sh = {rem_r, num_r[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_r});
    qfin   = {quo_r[DIV_W-2:0], qbit};

    case (st_r)
      BK_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          ent_nxt = pop_data;
          idx_nxt = '0;
          if (pop_data.status == ST_BAD || pop_data.status == ST_OVF) begin
            dur_nxt = '0;
            st_nxt  = BK_EMIT;
          end else if (pop_data.has_den) begin
            // (2*whole + d) / (2*d): rounds whole/d half up
            num_nxt  = DIV_BIAS + DIV_W'(pop_data.den);
            dvs_nxt  = DIV_W'({pop_data.den, 1'b0});
            rem_nxt  = '0;
            quo_nxt  = '0;
            step_nxt = STEP_W'(DIV_W);
            st_nxt   = BK_DIV;
          end else begin
            dur_nxt = DUR_PLAIN;
            st_nxt  = BK_EMIT;
          end
        end
      end
      BK_DIV: begin
        rem_nxt  = qbit ? DIV_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_W-1:0];
        quo_nxt  = qfin;
        num_nxt  = {num_r[DIV_W-2:0], 1'b0};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          dur_nxt = (qfin == '0) ? DUR_W'(1) : qfin[DUR_W-1:0];
          st_nxt  = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!ov_r || out_tready) begin
          load   = 1'b1;
          lastk  = (ent_r.status != ST_NOTE) || (NUM_W'(idx_r) + NUM_W'(1) == ent_r.num);
          ou_nxt = ent_r.status;
          ok_nxt = (ent_r.status == ST_NOTE) ? ent_r.keys[idx_r] : '0;
          od_nxt = dur_r;
          ol_nxt = lastk;
          if (lastk) st_nxt = BK_IDLE;
          else       idx_nxt = idx_r + KIDX_W'(1);
        end
      end
      default: st_nxt = BK_IDLE;
    endcase

    ov_nxt = load ? 1'b1 : (out_tready ? 1'b0 : ov_r);
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {6'b0, od_r, ok_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    num_r  <= num_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    dur_r  <= dur_nxt;
    idx_r  <= idx_nxt;
    ou_r   <= ou_nxt;
    ok_r   <= ok_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

endmodule

// ===== bench/midi_key_checker.sv =====
module midi_key_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_token
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [6:0] midi_key, [17:7] duration_ticks, [23:18] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        out_tlast,  // last_in_run
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,   // [3:0] default_octave
  output int          fail_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ntmk_pkg::*;

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_REST  = "r";
  localparam logic [7:0] CH_SHARP = "#";
  localparam logic [7:0] CH_FLAT  = "b";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_G     = "G";

  typedef enum logic [2:0] {
    PART_START, PART_SHARPS, PART_FLATS, PART_OCTAVE, PART_REST
  } part_phase_e;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [DUR_W-1:0] ticks;
    logic             last;
  } key_result_t;

  key_result_t key_results_q[$];

  // token being parsed
  logic [KEY_W-1:0] chord [MAX_CHORD_NOTES];
  int               n_chord;
  part_phase_e      phase;
  int               plen, semi, sharps, flats, part_oct;
  bit               is_rest, any_rest, bad, too_many;
  bit               in_den, den_digit, den_neg;
  int               den;
  logic [3:0]       dflt_octave;

  initial fail_count = 0;
  initial results_pending = 0;

  task report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task queue_result(input key_result_t r);
    key_results_q = {key_results_q, r};
  endtask

  task clear_part();
    phase    = PART_START;
    plen     = 0;
    semi     = 0;
    sharps   = 0;
    flats    = 0;
    part_oct = 0;
    is_rest  = 0;
  endtask

  task clear_token();
    clear_part();
    n_chord   = 0;
    any_rest  = 0;
    bad       = 0;
    too_many  = 0;
    in_den    = 0;
    den       = 0;
    den_digit = 0;
    den_neg   = 0;
  endtask

  task close_part();
    int oct, key;
    if (phase == PART_START) begin
      bad = 1;
      return;
    end
    if (is_rest) begin
      any_rest = 1;
      clear_part();
      return;
    end
    oct = (phase == PART_OCTAVE) ? part_oct : int'(dflt_octave);
    key = 12 * (oct + 1) + semi + sharps - flats;
    if (key > 127) begin
      bad = 1;
      return;
    end
    if (n_chord < MAX_CHORD_NOTES) chord[n_chord] = key[KEY_W-1:0];
    else too_many = 1;
    if (n_chord <= MAX_CHORD_NOTES) n_chord++;
    clear_part();
  endtask

  task den_char(input logic [7:0] c);
    if ((c == CH_PLUS || c == CH_MINUS) && plen == 0) begin
      den_neg = (c == CH_MINUS);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      den = den * 10 + int'(c - CH_ZERO);
      if (den > int'(DEN_SAT)) den = int'(DEN_SAT);
      den_digit = 1;
    end else begin
      bad = 1;
    end
    plen = 1;
  endtask

  task pitch_char(input logic [7:0] c);
    if (c == CH_PLUS) begin
      close_part();
      return;
    end
    if (c == CH_SLASH) begin
      close_part();
      in_den = 1;
      plen   = 0;
      return;
    end
    if (plen >= 4) begin
      bad = 1;
      return;
    end
    plen++;
    case (phase)
      PART_START: begin
        if (c == CH_REST || c == CH_MINUS) begin
          is_rest = 1;
          phase   = PART_REST;
        end else if (c >= CH_A && c <= CH_G) begin
          case (c - CH_A)
            0: semi = 9;
            1: semi = 11;
            2: semi = 0;
            3: semi = 2;
            4: semi = 4;
            5: semi = 5;
            default: semi = 7;
          endcase
          phase = PART_SHARPS;
        end else begin
          bad = 1;
        end
      end
      PART_SHARPS, PART_FLATS: begin
        if (c == CH_SHARP && phase == PART_SHARPS) begin
          sharps++;
        end else if (c == CH_FLAT) begin
          flats++;
          phase = PART_FLATS;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          part_oct = int'(c - CH_ZERO);
          phase    = PART_OCTAVE;
        end else begin
          bad = 1;
        end
      end
      default: bad = 1;
    endcase
  endtask

  // token end: queue one result per key, one rest, or one error
  task close_token();
    key_result_t r;
    int          ticks;
    ticks = TICKS_PER_QUARTER;
    if (!bad && !in_den) close_part();
    if (!bad && in_den) begin
      if (!den_digit || den_neg || den == 0) begin
        bad = 1;
      end else begin
        // whole note over den, rounded half up
        ticks = (2 * WHOLE_TICKS + den) / (2 * den);
        if (ticks == 0) ticks = 1;
      end
    end
    if (bad || too_many) begin
      r.status = bad ? ST_BAD : ST_OVF;
      r.key    = '0;
      r.ticks  = '0;
      r.last   = 1'b1;
      queue_result(r);
    end else if (n_chord > 0) begin
      for (int k = 0; k < n_chord && k < MAX_CHORD_NOTES; k++) begin
        r.status = ST_NOTE;
        r.key    = chord[k];
        r.ticks  = ticks[DUR_W-1:0];
        r.last   = (k + 1 == n_chord);
        queue_result(r);
      end
    end else begin
      r.status = ST_REST;
      r.key    = '0;
      r.ticks  = ticks[DUR_W-1:0];
      r.last   = 1'b1;
      queue_result(r);
    end
    clear_token();
  endtask

  task take_char(input logic [7:0] c, input logic last);
    if (!bad) begin
      if (in_den) den_char(c);
      else pitch_char(c);
    end
    if (last) close_token();
  endtask

  task check_result();
    key_result_t want;
    if (key_results_q.size() == 0) begin
      report_mismatch("unexpected result, status", out_tuser, 0);
      return;
    end
    want = key_results_q.pop_front();
    if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
    if (out_tdata[6:0] !== want.key) report_mismatch("midi_key", out_tdata[6:0], want.key);
    if (out_tdata[17:7] !== want.ticks)
      report_mismatch("duration_ticks", out_tdata[17:7], want.ticks);
    if (out_tlast !== want.last) report_mismatch("last_in_run", out_tlast, want.last);
    if (out_tdata[23:18] !== '0) report_mismatch("tdata pad", out_tdata[23:18], 0);
  endtask

  // results are checked before the same edge's character so queue order holds
  always @(posedge clk) begin
    if (!rst_n) begin
      key_results_q.delete();
      clear_token();
      dflt_octave = DEFAULT_OCTAVE_RST;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) dflt_octave = cfg_data;
      if (in_tvalid && in_tready) take_char(in_tdata, in_tlast);
    end
    results_pending = key_results_q.size();
  end

endmodule

// ===== bench/note_token_to_midi_keys_test.sv =====
module note_token_to_midi_keys_test;
  timeunit 1ns;
  timeprecision 1ps;

  // covers the back end's pop, divide and result items for one token, with margin
  localparam int DRAIN_CYCLES = 32;
  // longest legal quiet spell is a receiver stall or a drain, far below this
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_CHARS  = 12;

  typedef enum int { RX_OPEN, RX_CHOPPY, RX_STALLS } rx_mode_e;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] text_byte
  logic        in_tlast   = 1'b0; // end_of_token
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [6:0] midi_key, [17:7] duration_ticks, [23:18] zero
  logic [1:0]  out_tuser;         // [1:0] status
  logic        out_tlast;         // last_in_run
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data   = '0;   // [3:0] default_octave

  int          fail_count;
  int          results_pending;
  int          chars_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [7:0]  tok_chars[$];

  rx_mode_e    rx_mode = RX_OPEN;
  int          rx_mode_left = 0;
  int          rx_stall_left = 0;

  note_token_to_midi_keys i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // predicts every result from the accepted characters and compares
  midi_key_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: switches between always-ready, randomly ready and long-stall stretches.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(16, 64);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:   out_tready = 1'b1;
      RX_CHOPPY: out_tready = ($urandom_range(0, 2) != 0);
      default: begin
        if (rx_stall_left > 0) begin
          out_tready = 1'b0;
          rx_stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
          out_tready    = 1'b0;
          rx_stall_left = $urandom_range(4, 20);
        end else begin
          out_tready = 1'b1;
        end
      end
    endcase
  end

  // Watchdog: quiet cycles on all three channels.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One character item. Entered and left at a falling edge. The sender runs
  // in bursts; a gap of zero keeps valid high across items.
  task send_char(input logic [7:0] ch, input logic last);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left--;
    chars_sent++;
  endtask

  task send_token();
    for (int i = 0; i < tok_chars.size(); i++)
      send_char(tok_chars[i], i == tok_chars.size() - 1);
  endtask

  task add_char(input logic [7:0] ch);
    tok_chars = {tok_chars, ch};
  endtask

  task send_text(input string s);
    tok_chars.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_token();
  endtask

  // Register writes only with the block drained.
  task set_default_octave(input logic [3:0] oct);
    in_tvalid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data  = oct;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly well-formed chords with random pitches and denominators; some
  // pure noise, some tokens with one character broken.
  task make_token();
    int    kind, parts, sh, fl, den;
    string digits;
    logic [7:0] extra;
    tok_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
      return;
    end
    // occasionally enough parts to fill or overflow the chord store
    parts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 3);
    for (int p = 0; p < parts; p++) begin
      if (p > 0) add_char("+");
      if ($urandom_range(0, 9) == 0) begin
        add_char($urandom_range(0, 1) ? "r" : "-");
      end else begin
        add_char("A" + 8'($urandom_range(0, 6)));
        sh = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(0, 1);
        fl = (sh == 3) ? 0 : $urandom_range(0, 2 - sh);
        repeat (sh) add_char("#");
        repeat (fl) add_char("b");
        if ($urandom_range(0, 9) < 7) add_char("0" + 8'($urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      add_char("/");
      case ($urandom_range(0, 9))
        0: add_char("+");
        1: add_char("-");
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          case ($urandom_range(0, 7))
            0: den = 1;
            1: den = 2;
            2: den = 4;
            3: den = 8;
            4: den = 16;
            5: den = 3;
            6: den = 6;
            default: den = 12;
          endcase
        end
        3: den = $urandom_range(1, 4095);
        4: den = $urandom_range(4096, 999999);  // saturates
        default: den = $urandom_range(0, 1) ? 0 : $urandom_range(5, 99);
      endcase
      digits = $sformatf("%0d", den);
      for (int i = 0; i < digits.len(); i++) add_char(digits[i]);
    end
    if (kind >= 88) begin
      case ($urandom_range(0, 4))
        0: extra = "+";
        1: extra = "/";
        2: extra = "#";
        3: extra = "b";
        default: extra = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 2))
        0: tok_chars[$urandom_range(0, tok_chars.size() - 1)] = 8'($urandom_range(0, 255));
        1: tok_chars.insert($urandom_range(0, tok_chars.size() - 1), extra);
        default: if (tok_chars.size() > 1) void'(tok_chars.pop_back());
      endcase
    end
  endtask

  task run_random(input int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      make_token();
      send_token();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed, default octave from reset
    send_text("C4");
    send_text("G9");            // top key
    send_text("B9");            // key past 127
    send_text("Cb0");           // lowest octave, flat
    send_text("C###");          // max sharps, default octave
    send_text("C##b");
    send_text("C##b4");         // part too long
    send_text("Cb#");           // sharp after flat
    send_text("Dr");
    send_text("r");
    send_text("r+C4+-");        // rests hidden by a key
    send_text("r+-");           // rests only
    send_text("+C");            // empty parts
    send_text("C+");
    send_text("C++D");
    send_text("/4");
    send_text("C/1");
    send_text("C/3");
    send_text("C/+16");
    send_text("C/-4");
    send_text("C/0");
    send_text("C/");
    send_text("C/4/2");
    send_text("C/4+");
    send_text("C/99999");       // saturated denominator
    send_text("C+D+E+F+G+A+B+C5");
    send_text("C+D+E+F+G+A+B+C5+D5");     // one key too many
    send_text("C+D+E+F+G+A+B+C5+D5+x");   // overflow and malformed
    tok_chars.delete();
    add_char(8'h00);
    add_char(8'hFF);
    send_token();

    // random phases across register settings, extremes included
    run_random(PHASE_CHARS);
    set_default_octave(4'd0);
    run_random(PHASE_CHARS);
    set_default_octave(4'd9);
    run_random(PHASE_CHARS);
    set_default_octave(4'd15);  // no-digit notes are all out of range
    run_random(PHASE_CHARS / 2);
    set_default_octave(4'($urandom_range(0, 15)));
    run_random(PHASE_CHARS);
    set_default_octave(4'($urandom_range(1, 8)));
    run_random(PHASE_CHARS);

    in_tvalid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ntmk_pkg.sv
hw/rtl/ntmk_front.sv
hw/rtl/ntmk_fifo.sv
hw/rtl/ntmk_back.sv
hw/rtl/note_token_to_midi_keys.sv
bench/midi_key_checker.sv
bench/note_token_to_midi_keys_test.sv
